/* src/ipd_pkg.sv */
// Shared types, constants and the command lookup of the IR pulse-distance decoder.
// No dependencies; every other file in src imports this package.
`timescale 1ns / 1ps
`default_nettype none
package ipd_pkg;

	localparam int IntervalW  = 14;
	localparam int FrameBits  = 32;
	localparam int PosW       = $clog2(FrameBits);
	localparam int CmdW       = 3;
	localparam int CfgIndexW  = 3;
	localparam int NumCmds    = 5;

	// Configuration register indexes
	localparam logic [CfgIndexW-1:0] REG_START_LOW  = 3'd0;
	localparam logic [CfgIndexW-1:0] REG_START_HIGH = 3'd1;
	localparam logic [CfgIndexW-1:0] REG_ZERO_LOW   = 3'd2;
	localparam logic [CfgIndexW-1:0] REG_ZERO_HIGH  = 3'd3;
	localparam logic [CfgIndexW-1:0] REG_ONE_LOW    = 3'd4;
	localparam logic [CfgIndexW-1:0] REG_ONE_HIGH   = 3'd5;

	// Window reset values
	localparam logic [IntervalW-1:0] START_LOW_RST  = 14'd8800;
	localparam logic [IntervalW-1:0] START_HIGH_RST = 14'd9200;
	localparam logic [IntervalW-1:0] ZERO_LOW_RST   = 14'd900;
	localparam logic [IntervalW-1:0] ZERO_HIGH_RST  = 14'd1300;
	localparam logic [IntervalW-1:0] ONE_LOW_RST    = 14'd2000;
	localparam logic [IntervalW-1:0] ONE_HIGH_RST   = 14'd2400;

	// Command codes
	localparam logic [CmdW-1:0] CMD_POWER     = 3'd0;
	localparam logic [CmdW-1:0] CMD_CHAN_UP   = 3'd1;
	localparam logic [CmdW-1:0] CMD_CHAN_DOWN = 3'd2;
	localparam logic [CmdW-1:0] CMD_VOL_UP    = 3'd3;
	localparam logic [CmdW-1:0] CMD_VOL_DOWN  = 3'd4;
	localparam logic [CmdW-1:0] CMD_NONE      = 3'd5;

	localparam logic [FrameBits-1:0] WORD_POWER     = 32'hE0E040BF;
	localparam logic [FrameBits-1:0] WORD_CHAN_UP   = 32'hE0E048B7;
	localparam logic [FrameBits-1:0] WORD_CHAN_DOWN = 32'hE0E008F7;
	localparam logic [FrameBits-1:0] WORD_VOL_UP    = 32'hE0E0E01F;
	localparam logic [FrameBits-1:0] WORD_VOL_DOWN  = 32'hE0E0D02F;

	// Interval classification handed from the window compare to the frame logic
	typedef struct packed {
		logic start;
		logic zero;
		logic one;
	} class_t;

	function automatic logic [CmdW-1:0] match_command(input logic [FrameBits-1:0] word);
		logic [CmdW-1:0] code;
		code = CMD_NONE;
		if (word == WORD_POWER)
			code = CMD_POWER;
		else if (word == WORD_CHAN_UP)
			code = CMD_CHAN_UP;
		else if (word == WORD_CHAN_DOWN)
			code = CMD_CHAN_DOWN;
		else if (word == WORD_VOL_UP)
			code = CMD_VOL_UP;
		else if (word == WORD_VOL_DOWN)
			code = CMD_VOL_DOWN;
		return code;
	endfunction

endpackage
`default_nettype wire

/* src/ipd_window.sv */
// Window bound registers and the exclusive-range compares that classify an interval.
// Depends on ipd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ipd_window (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [ipd_pkg::CfgIndexW-1:0] cfg_index,
	input  wire logic [ipd_pkg::IntervalW-1:0] cfg_wdata,
	input  wire logic [ipd_pkg::IntervalW-1:0] interval,
	output ipd_pkg::class_t                    cls
);
	import ipd_pkg::*;

	logic [IntervalW-1:0] start_low_q, start_high_q;
	logic [IntervalW-1:0] zero_low_q, zero_high_q;
	logic [IntervalW-1:0] one_low_q, one_high_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_low_q  <= START_LOW_RST;
			start_high_q <= START_HIGH_RST;
			zero_low_q   <= ZERO_LOW_RST;
			zero_high_q  <= ZERO_HIGH_RST;
			one_low_q    <= ONE_LOW_RST;
			one_high_q   <= ONE_HIGH_RST;
		end else if (cfg_we) begin
			// drop writes beyond the last register
			case (cfg_index)
				REG_START_LOW:  start_low_q  <= cfg_wdata;
				REG_START_HIGH: start_high_q <= cfg_wdata;
				REG_ZERO_LOW:   zero_low_q   <= cfg_wdata;
				REG_ZERO_HIGH:  zero_high_q  <= cfg_wdata;
				REG_ONE_LOW:    one_low_q    <= cfg_wdata;
				REG_ONE_HIGH:   one_high_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		cls.start = (interval > start_low_q) && (interval < start_high_q);
		cls.zero  = (interval > zero_low_q)  && (interval < zero_high_q);
		cls.one   = (interval > one_low_q)   && (interval < one_high_q);
	end

endmodule
`default_nettype wire

/* src/ipd_frame.sv */
// Frame assembly: in-frame flag, bit position and frame bits, plus the end-of-frame result.
// Depends on ipd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ipd_frame (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          valid,
	input  wire logic                          advance,
	input  wire ipd_pkg::class_t               cls,
	output logic                               emit,
	output logic [ipd_pkg::FrameBits-1:0]      word_next,
	output logic [ipd_pkg::CmdW-1:0]           cmd_next
);
	import ipd_pkg::*;

	logic [FrameBits-1:0] frame_bits_q;
	logic [PosW-1:0]      bit_pos_q;
	logic                 in_frame_q;
	logic [PosW-1:0]      bit_idx;
	logic                 take_bit;
	logic                 last_pos;

	// first bit received lands in the MSB
	assign bit_idx  = ~bit_pos_q;
	assign take_bit = !cls.start && in_frame_q;
	assign last_pos = (bit_pos_q == PosW'(FrameBits - 1));
	assign emit     = valid && take_bit && last_pos;

	always_comb begin
		word_next = frame_bits_q;
		if (cls.zero)
			word_next[bit_idx] = 1'b0;
		if (cls.one)
			word_next[bit_idx] = 1'b1;
	end

	assign cmd_next = match_command(word_next);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_bits_q <= '0;
			bit_pos_q    <= '0;
			in_frame_q   <= 1'b0;
		end else if (advance) begin
			if (cls.start) begin
				in_frame_q <= 1'b1;
			end else if (in_frame_q) begin
				frame_bits_q <= word_next;
				bit_pos_q    <= bit_pos_q + PosW'(1);
				if (last_pos)
					in_frame_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

/* src/ir_pulse_distance_command_decoder.sv */
// Top level of the IR pulse-distance command decoder: input register, window compare,
// frame assembly and output register. Depends on ipd_pkg, ipd_window and ipd_frame.
`timescale 1ns / 1ps
`default_nettype none
// One transaction on the slave side carries one falling-edge-to-falling-edge interval.
// An interval inside the start window opens a frame; the next 32 non-start intervals each
// fill one bit, MSB first (zero window gives 0, one window gives 1, anything else keeps the
// old bit). After the 32nd bit one master-side transaction carries the frame word and
// the matched command code (5 when no known command matches). The block accepts one
// interval per clock unless stalled: the interval is captured in the input register, then
// classified and folded into the frame as it advances, which also loads the output
// register and raises m_tvalid on the last interval of a frame. Input acceptance only stalls
// when a finished result is still held in the output register and another one is due.
module ir_pulse_distance_command_decoder (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [ipd_pkg::CfgIndexW-1:0] cfg_index,
	input  wire logic [ipd_pkg::IntervalW-1:0] cfg_wdata,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [15:0]                   s_tdata,   // [13:0] interval
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [39:0]                        m_tdata    // [31:0] frame_word, [34:32] command
);
	import ipd_pkg::*;

	logic                 valid_s1;
	logic [IntervalW-1:0] interval_s1;
	class_t               cls;
	logic                 emit;
	logic                 adv_s1;
	logic                 out_free;
	logic [FrameBits-1:0] word_next;
	logic [CmdW-1:0]      cmd_next;
	logic [FrameBits-1:0] frame_word_q;
	logic [CmdW-1:0]      command_q;

	assign out_free = !m_tvalid || m_tready;
	// hold the interval only when it completes a frame and the last result is still waiting
	assign adv_s1   = valid_s1 && (!emit || out_free);
	assign s_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid)
			interval_s1 <= s_tdata[IntervalW-1:0];
	end

	ipd_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.interval  (interval_s1),
		.cls       (cls)
	);

	ipd_frame u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid     (valid_s1),
		.advance   (adv_s1),
		.cls       (cls),
		.emit      (emit),
		.word_next (word_next),
		.cmd_next  (cmd_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid <= 1'b0;
		else if (adv_s1 && emit)
			m_tvalid <= 1'b1;
		else if (m_tready)
			m_tvalid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && emit) begin
			frame_word_q <= word_next;
			command_q    <= cmd_next;
		end
	end

	assign m_tdata = {5'd0, command_q, frame_word_q};

endmodule
`default_nettype wire
